// ===== hdl/sie_pkg.sv =====
package sie_pkg;

	localparam int DataW     = 32;
	localparam int OffW      = 16;
	localparam int MemWords  = 256;
	localparam int MemAddrW  = $clog2(MemWords);

	typedef logic [DataW-1:0] word_t;

	typedef enum logic [2:0] {
		OP_ADD   = 3'd0,
		OP_NAND  = 3'd1,
		OP_MULT  = 3'd2,
		OP_LOAD  = 3'd3,
		OP_STORE = 3'd4,
		OP_BEQ   = 3'd5,
		OP_HALT  = 3'd6,
		OP_NOOP  = 3'd7
	} op_t;

	typedef struct packed {
		logic                en;
		logic [MemAddrW-1:0] addr;
		word_t               data;
	} mem_wr_t;

endpackage

// ===== hdl/sie_regfile.sv =====
module sie_regfile #(
	parameter int NUM_REGS = 8,
	localparam int IdxW = $clog2(NUM_REGS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [IdxW-1:0]   rd_addr0,
	input  logic [IdxW-1:0]   rd_addr1,
	output sie_pkg::word_t    rd_data0,
	output sie_pkg::word_t    rd_data1,
	input  logic              wr_en,
	input  logic [IdxW-1:0]   wr_addr,
	input  sie_pkg::word_t    wr_data
);

	sie_pkg::word_t        mem [NUM_REGS];
	logic [NUM_REGS-1:0]   vld_q;
	sie_pkg::word_t        rd_data0_q;
	sie_pkg::word_t        rd_data1_q;
	logic                  rd_vld0_q;
	logic                  rd_vld1_q;

	// read-before-write: a same-edge write is seen through forwarding upstream
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data0_q <= mem[rd_addr0];
			rd_data1_q <= mem[rd_addr1];
		end
	end

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld0_q <= 1'b0;
			rd_vld1_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld0_q <= vld_q[rd_addr0];
				rd_vld1_q <= vld_q[rd_addr1];
			end
		end
	end

	assign rd_data0 = rd_vld0_q ? rd_data0_q : '0;
	assign rd_data1 = rd_vld1_q ? rd_data1_q : '0;

endmodule

// ===== hdl/sie_dmem.sv =====
module sie_dmem (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [sie_pkg::MemAddrW-1:0]  rd_addr,
	output sie_pkg::word_t                rd_data,
	input  sie_pkg::mem_wr_t              wr
);

	sie_pkg::word_t                 mem [sie_pkg::MemWords];
	logic [sie_pkg::MemWords-1:0]   vld_q;
	sie_pkg::word_t                 rd_data_q;
	logic                           rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

// ===== hdl/sie_alu.sv =====
module sie_alu (
	input  sie_pkg::op_t    op,
	input  sie_pkg::word_t  src0,
	input  sie_pkg::word_t  src1,
	output sie_pkg::word_t  result
);

	// src0 is the base/first source, src1 the second source or store data
	always_comb begin
		unique case (op)
			sie_pkg::OP_ADD:   result = src0 + src1;
			sie_pkg::OP_NAND:  result = ~(src0 & src1);
			sie_pkg::OP_MULT:  result = src0 * src1;
			sie_pkg::OP_STORE: result = src1;
			default:           result = '0;
		endcase
	end

endmodule

// ===== hdl/simple_isa_execute_unit.sv =====
// Executes one decoded instruction per input word against an internal register file,
// a 256-word data memory and a program counter. A new word is accepted every cycle
// unless a result word waits for out_ready; each word passes register read, execute
// with data memory access and write-back and leaves through an output register, so
// throughput is one word per cycle unless stalled, set by the single write port of the
// register file with forwarding of the two results still in flight. Register file and
// memory read as zero after reset without a clearing pass. Once a halt has executed,
// later words leave state untouched and report the current pc with halted set.
module simple_isa_execute_unit #(
	parameter int NUM_REGS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         opcode,
	input  logic [2:0]         reg_first,
	input  logic [2:0]         reg_second,
	input  logic signed [15:0] field_third,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] pc_value,
	output logic               halted,
	output logic               branch_taken,
	output logic signed [31:0] written_value
);

	localparam int RegIdxW = $clog2(NUM_REGS);
	localparam int Pow8Mod = 256 % NUM_REGS;

	typedef logic [255:0][RegIdxW-1:0] mod_tab_t;

	function automatic mod_tab_t build_mod_tab();
		mod_tab_t t;
		for (int i = 0; i < 256; i++) begin
			t[i] = RegIdxW'(i % NUM_REGS);
		end
		return t;
	endfunction

	localparam mod_tab_t ModTab = build_mod_tab();

	// accept side
	logic                  adv;
	sie_pkg::op_t          op_in;
	logic [7:0]            fold_in;
	logic [RegIdxW-1:0]    ra_in;
	logic [RegIdxW-1:0]    rb_in;
	logic [RegIdxW-1:0]    rc_in;
	logic [RegIdxW-1:0]    p1_in;

	// stage 1
	logic                  valid_s1;
	sie_pkg::op_t          op_s1;
	logic [RegIdxW-1:0]    ra_s1;
	logic [RegIdxW-1:0]    rb_s1;
	logic [RegIdxW-1:0]    p1_s1;
	logic [15:0]           off_s1;
	sie_pkg::word_t        rf_rd0;
	sie_pkg::word_t        rf_rd1;
	sie_pkg::word_t        b_v;
	sie_pkg::word_t        p1_v;
	sie_pkg::word_t        offx;
	sie_pkg::word_t        ea;
	sie_pkg::word_t        alu_res;
	sie_pkg::word_t        pc_next;
	logic                  live_s1;
	logic                  taken_s1;
	logic                  halt_set;
	logic                  rf_we_in;
	sie_pkg::mem_wr_t      dm_wr;

	// architectural state
	logic                  halt_q;
	sie_pkg::word_t        pc_q;

	// stage 2
	logic                  valid_s2;
	logic                  rf_we_s2;
	logic                  is_load_s2;
	logic [RegIdxW-1:0]    ra_s2;
	sie_pkg::word_t        val_s2;
	sie_pkg::word_t        pc_s2;
	logic                  halted_s2;
	logic                  taken_s2;
	sie_pkg::word_t        dm_rd;
	sie_pkg::word_t        wv_s2;

	// stage 3 (output)
	logic                  valid_s3;
	logic                  rf_we_s3;
	logic [RegIdxW-1:0]    ra_s3;
	sie_pkg::word_t        wv_s3;
	sie_pkg::word_t        pc_s3;
	logic                  halted_s3;
	logic                  taken_s3;

	assign adv      = !valid_s3 || out_ready;
	assign in_ready = adv;
	assign op_in    = sie_pkg::op_t'(opcode);

	// register index of the 16-bit field: fold the two bytes, then one table lookup
	always_comb begin
		fold_in = 8'(ModTab[field_third[15:8]]) * 8'(Pow8Mod) + 8'(ModTab[field_third[7:0]]);
		rc_in   = ModTab[fold_in];
		ra_in   = ModTab[8'(reg_first)];
		rb_in   = ModTab[8'(reg_second)];
		if (op_in == sie_pkg::OP_ADD || op_in == sie_pkg::OP_NAND
			|| op_in == sie_pkg::OP_MULT) begin
			p1_in = rc_in;
		end else begin
			p1_in = ra_in;
		end
	end

	sie_regfile #(
		.NUM_REGS (NUM_REGS)
	) u_regfile (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (adv),
		.rd_addr0 (rb_in),
		.rd_addr1 (p1_in),
		.rd_data0 (rf_rd0),
		.rd_data1 (rf_rd1),
		.wr_en    (adv && rf_we_s2),
		.wr_addr  (ra_s2),
		.wr_data  (wv_s2)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1  <= op_in;
			ra_s1  <= ra_in;
			rb_s1  <= rb_in;
			p1_s1  <= p1_in;
			off_s1 <= field_third;
		end
	end

	// forward results of the two words still ahead of this one
	always_comb begin
		priority if (rf_we_s2 && ra_s2 == rb_s1) begin
			b_v = wv_s2;
		end else if (rf_we_s3 && ra_s3 == rb_s1) begin
			b_v = wv_s3;
		end else begin
			b_v = rf_rd0;
		end
		priority if (rf_we_s2 && ra_s2 == p1_s1) begin
			p1_v = wv_s2;
		end else if (rf_we_s3 && ra_s3 == p1_s1) begin
			p1_v = wv_s3;
		end else begin
			p1_v = rf_rd1;
		end
	end

	sie_alu u_alu (
		.op     (op_s1),
		.src0   (b_v),
		.src1   (p1_v),
		.result (alu_res)
	);

	always_comb begin
		offx     = {{(sie_pkg::DataW - sie_pkg::OffW){off_s1[15]}}, off_s1};
		ea       = b_v + offx;
		live_s1  = valid_s1 && !halt_q;
		taken_s1 = live_s1 && op_s1 == sie_pkg::OP_BEQ && p1_v == b_v;
		halt_set = live_s1 && op_s1 == sie_pkg::OP_HALT;
		rf_we_in = live_s1 && (op_s1 == sie_pkg::OP_ADD || op_s1 == sie_pkg::OP_NAND
			|| op_s1 == sie_pkg::OP_MULT || op_s1 == sie_pkg::OP_LOAD);
		pc_next  = taken_s1 ? pc_q + offx : pc_q;
		dm_wr.en   = adv && live_s1 && op_s1 == sie_pkg::OP_STORE;
		dm_wr.addr = ea[sie_pkg::MemAddrW-1:0];
		dm_wr.data = p1_v;
	end

	sie_dmem u_dmem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (adv),
		.rd_addr (ea[sie_pkg::MemAddrW-1:0]),
		.rd_data (dm_rd),
		.wr      (dm_wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			rf_we_s2 <= 1'b0;
			rf_we_s3 <= 1'b0;
			halt_q   <= 1'b0;
			pc_q     <= '0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			rf_we_s2 <= rf_we_in;
			rf_we_s3 <= rf_we_s2;
			halt_q   <= halt_q || halt_set;
			pc_q     <= pc_next;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			is_load_s2 <= live_s1 && op_s1 == sie_pkg::OP_LOAD;
			ra_s2      <= ra_s1;
			val_s2     <= live_s1 ? alu_res : '0;
			pc_s2      <= pc_next;
			halted_s2  <= halt_q || halt_set;
			taken_s2   <= taken_s1;
			ra_s3      <= ra_s2;
			wv_s3      <= wv_s2;
			pc_s3      <= pc_s2;
			halted_s3  <= halted_s2;
			taken_s3   <= taken_s2;
		end
	end

	assign wv_s2 = is_load_s2 ? dm_rd : val_s2;

	assign out_valid     = valid_s3;
	assign pc_value      = pc_s3;
	assign halted        = halted_s3;
	assign branch_taken  = taken_s3;
	assign written_value = wv_s3;

endmodule

// ===== hdl/sie_checker.sv =====
module sie_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] pc_value,
	input logic        halted,
	input logic        branch_taken,
	input logic [31:0] written_value
);

	logic        in_acc;
	logic        out_acc;
	logic [2:0]  cnt_q;
	logic        seen_halt_q;
	logic [31:0] last_pc_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// words in flight, last reported pc, halt seen on an earlier word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			seen_halt_q <= 1'b0;
			last_pc_q   <= '0;
		end else begin
			cnt_q       <= 3'(cnt_q + 3'(in_acc) - 3'(out_acc));
			seen_halt_q <= seen_halt_q || (out_acc && halted);
			if (out_acc) begin
				last_pc_q <= pc_value;
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pc_value) && $stable(halted)
			&& $stable(branch_taken) && $stable(written_value))
		else $error("output word changed while stalled");

	a_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd3 && (cnt_q != 3'd0 || !out_valid))
		else $error("output word without a matching input word");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seen_halt_q |-> halted && !branch_taken && written_value == 32'd0)
		else $error("word after halt changed state");

	a_pc_moves_on_branch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !branch_taken |-> pc_value == last_pc_q)
		else $error("pc moved without a taken branch");

endmodule

bind simple_isa_execute_unit sie_checker u_sie_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.pc_value      (pc_value),
	.halted        (halted),
	.branch_taken  (branch_taken),
	.written_value (written_value)
);

// ===== verif/sie_exec_checker.sv =====
// Watches both channels, runs its own copy of the register file, data memory and pc,
// and compares every result word against the oldest predicted one.
module sie_exec_checker
	import sie_pkg::*;
#(
	parameter int NUM_REGS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [2:0]         opcode,
	input  logic [2:0]         reg_first,
	input  logic [2:0]         reg_second,
	input  logic signed [15:0] field_third,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [31:0] pc_value,
	input  logic               halted,
	input  logic               branch_taken,
	input  logic signed [31:0] written_value,
	output int                 mismatch_count,
	output int                 outstanding
);

	typedef struct {
		word_t pc;
		logic  halt;
		logic  taken;
		word_t wval;
	} exec_result_t;

	exec_result_t result_q[$];
	exec_result_t want;
	word_t        regs [NUM_REGS];
	word_t        dmem [MemWords];
	word_t        pc;
	logic         halt_seen;
	int           fails;

	function automatic exec_result_t execute_word(op_t op, logic [2:0] ra_f, logic [2:0] rb_f,
	                                              logic [15:0] f);
		int unsigned  ia, ib, ic, maddr;
		word_t        a, b, c, off, sum;
		exec_result_t r;
		ia = ra_f % NUM_REGS;
		ib = rb_f % NUM_REGS;
		ic = f % NUM_REGS;
		off = {{16{f[15]}}, f};
		r.taken = 1'b0;
		r.wval = '0;
		if (!halt_seen) begin
			a = regs[ia];
			b = regs[ib];
			c = regs[ic];
			sum = b + off;
			maddr = sum % MemWords;
			case (op)
				OP_ADD: begin
					r.wval = b + c;
					regs[ia] = r.wval;
				end
				OP_NAND: begin
					r.wval = ~(b & c);
					regs[ia] = r.wval;
				end
				OP_MULT: begin
					r.wval = b * c;
					regs[ia] = r.wval;
				end
				OP_LOAD: begin
					r.wval = dmem[maddr];
					regs[ia] = r.wval;
				end
				OP_STORE: begin
					r.wval = a;
					dmem[maddr] = a;
				end
				OP_BEQ: begin
					if (a == b) begin
						pc = pc + off;
						r.taken = 1'b1;
					end
				end
				OP_HALT: halt_seen = 1'b1;
				default: ;
			endcase
		end
		r.pc = pc;
		r.halt = halt_seen;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) regs[i] = '0;
			for (int i = 0; i < MemWords; i++) dmem[i] = '0;
			pc = '0;
			halt_seen = 1'b0;
			fails = 0;
			result_q.delete();
			mismatch_count <= 0;
			outstanding <= 0;
		end else begin
			if (in_valid && in_ready)
				result_q.push_back(execute_word(op_t'(opcode), reg_first, reg_second,
				                                field_third));
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%0t: unexpected result word pc=%h halted=%b taken=%b wval=%h",
						         $realtime, pc_value, halted, branch_taken, written_value);
				end else begin
					want = result_q.pop_front();
					if (want.pc !== pc_value || want.halt !== halted ||
					    want.taken !== branch_taken || want.wval !== written_value) begin
						fails++;
						if (fails <= 10)
							$display("%0t: result word exp pc=%h halted=%b taken=%b wval=%h, got pc=%h halted=%b taken=%b wval=%h",
							         $realtime, want.pc, want.halt, want.taken, want.wval,
							         pc_value, halted, branch_taken, written_value);
					end
				end
			end
			outstanding <= result_q.size();
			mismatch_count <= fails;
		end
	end

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
	import sie_pkg::*;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid;
	logic               in_ready;
	logic [2:0]         opcode;
	logic [2:0]         reg_first;
	logic [2:0]         reg_second;
	logic signed [15:0] field_third;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] pc_value;
	logic               halted;
	logic               branch_taken;
	logic signed [31:0] written_value;
	int                 mismatch_count;
	int                 outstanding;
	int                 sent_count = 0;

	simple_isa_execute_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.reg_first    (reg_first),
		.reg_second   (reg_second),
		.field_third  (field_third),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pc_value     (pc_value),
		.halted       (halted),
		.branch_taken (branch_taken),
		.written_value(written_value)
	);

	sie_exec_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.opcode        (opcode),
		.reg_first     (reg_first),
		.reg_second    (reg_second),
		.field_third   (field_third),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pc_value      (pc_value),
		.halted        (halted),
		.branch_taken  (branch_taken),
		.written_value (written_value),
		.mismatch_count(mismatch_count),
		.outstanding   (outstanding)
	);

	always #6 clk = ~clk;

	// mostly back to back, sometimes a few cycles, rarely a long pause
	function automatic int gap_len();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 55) return 0;
		if (pick < 85) return $urandom_range(1, 3);
		if (pick < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// call at a rising edge; returns at the edge after acceptance plus the gap
	task automatic issue(input op_t op, input logic [2:0] ra, input logic [2:0] rb,
	                     input logic [15:0] f, input int gap);
		in_valid <= 1'b1;
		opcode <= op;
		reg_first <= ra;
		reg_second <= rb;
		field_third <= f;
		do @(posedge clk); while (!in_ready);
		sent_count++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic issue_random(input int gap);
		op_t         op;
		logic [2:0]  ra, rb;
		logic [15:0] f;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 14) op = OP_ADD;
		else if (pick < 26) op = OP_NAND;
		else if (pick < 38) op = OP_MULT;
		else if (pick < 56) op = OP_LOAD;
		else if (pick < 74) op = OP_STORE;
		else if (pick < 94) op = OP_BEQ;
		else op = OP_NOOP;
		ra = 3'($urandom_range(0, 7));
		rb = 3'($urandom_range(0, 7));
		f = 16'($urandom_range(0, 16'hffff));
		// same register on both sides so branches get taken often enough
		if (op == OP_BEQ && $urandom_range(0, 2) == 0) rb = ra;
		issue(op, ra, rb, f, gap);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	initial begin
		int gap;
		int burst_left;
		in_valid = 1'b0;
		opcode = OP_NOOP;
		reg_first = '0;
		reg_second = '0;
		field_third = '0;
		burst_left = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(OP_NAND,  3'd1, 3'd0, 16'h0000, gap_len());   // r1 = -1
		issue(OP_ADD,   3'd2, 3'd1, 16'hfff9, gap_len());   // upper bits of rc ignored
		issue(OP_MULT,  3'd3, 3'd2, 16'h8002, gap_len());
		issue(OP_STORE, 3'd2, 3'd0, 16'h7fff, gap_len());
		issue(OP_LOAD,  3'd6, 3'd0, 16'h7fff, gap_len());
		issue(OP_STORE, 3'd1, 3'd1, 16'h8000, gap_len());   // address wraps below zero
		issue(OP_LOAD,  3'd7, 3'd2, 16'h0001, gap_len());
		issue(OP_LOAD,  3'd5, 3'd0, 16'h0005, gap_len());   // untouched memory word
		issue(OP_BEQ,   3'd0, 3'd0, 16'h0000, gap_len());   // taken, pc stays
		issue(OP_BEQ,   3'd1, 3'd7, 16'h7fff, gap_len());
		issue(OP_BEQ,   3'd1, 3'd2, 16'h0005, gap_len());   // not taken
		issue(OP_BEQ,   3'd3, 3'd3, 16'h8000, gap_len());
		issue(OP_NOOP,  3'd7, 3'd7, 16'hffff, gap_len());
		issue(OP_ADD,   3'd0, 3'd1, 16'h0002, gap_len());   // r0 is writable
		issue(OP_NAND,  3'd7, 3'd7, 16'hfff3, gap_len());
		issue(OP_MULT,  3'd4, 3'd7, 16'h0007, gap_len());
		drain();

		for (int n = 0; n < 1600; n++) begin
			if (burst_left == 0 && $urandom_range(0, 49) == 0)
				burst_left = $urandom_range(40, 80);
			if (burst_left > 0) begin
				burst_left--;
				gap = 0;
			end else begin
				gap = gap_len();
			end
			issue_random(gap);
			if (n == 800) drain();
		end
		drain();

		// halt, then one word of every kind that must be ignored
		issue(OP_HALT, 3'd0, 3'd0, 16'h0000, gap_len());
		for (int k = 0; k < 8; k++)
			issue(op_t'(k), 3'(k), 3'(k), 16'h0040, gap_len());
		drain();
		repeat (8) @(posedge clk);

		if (mismatch_count == 0 && outstanding == 0)
			$display("simple_isa_execute_unit: match");
		else
			$display("simple_isa_execute_unit: mismatch");
		$finish;
	end

	// result side: random ready pattern, plus one long hold-off so the pipe backs up
	initial begin
		int  run;
		bit  long_hold_done;
		out_ready = 1'b0;
		long_hold_done = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!long_hold_done && sent_count >= 400) begin
				long_hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (120) @(posedge clk);
			end
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
			out_ready <= 1'b1;
			repeat (run) @(posedge clk);
			run = gap_len();
			if (run > 0) begin
				out_ready <= 1'b0;
				repeat (run) @(posedge clk);
			end
		end
	end

	initial begin
		#12_000_000;
		$display("simple_isa_execute_unit: mismatch");
		$finish;
	end

endmodule
